>>> src/cpp_pkg.sv
// Shared types and constants of the closest point pair block.
package cpp_pkg;

    // Fixed widths of the channel fields
    localparam int COORD_W = 10;
    localparam int DIST_W  = 21;

    // One input item: a grid point and the end-of-set mark
    typedef struct packed {
        logic [COORD_W-1:0] point_row;
        logic [COORD_W-1:0] point_col;
        logic               last_point;
    } point_item_t;

    // One result item: the closest pair, its squared distance and flags
    typedef struct packed {
        logic [COORD_W-1:0] first_row;
        logic [COORD_W-1:0] first_col;
        logic [COORD_W-1:0] second_row;
        logic [COORD_W-1:0] second_col;
        logic [DIST_W-1:0]  min_dist_sq;
        logic               too_few;
        logic               overflowed;
    } pair_result_t;

endpackage

>>> src/cpp_chan_if.sv
// Valid/ready channel interface carrying one item per handshake.
interface cpp_chan_if #(
    parameter type data_t = logic
);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

>>> src/closest_point_pair.sv
// Closest point pair: point store, pair-scan sequencer and result register.
//
// Points arrive on the points channel, one item per cycle while the block is
// idle, and are written into an on-chip store in arrival order. The item
// marked last_point closes the set and starts the search. The block then
// drops ready and walks every pair (i, j), i < j, reading one stored point
// per cycle into a pipelined squared-distance unit that keeps the smallest
// distance seen; the first pair in load order wins a tie.
// After the last point is taken, the result is offered once the pair scan,
// the drain of the distance unit and the fetch of the best pair are done.
// One memory read port feeds the distance unit, one pair per cycle within
// an outer index, and each outer index first fetches its own point.
// The single result item then waits in the output register until the
// receiver takes it; the block stays not ready while the result is stalled.
// Sets of fewer than two points give too_few with zero pair fields at once.
// Points past MAX_POINTS are dropped and reported through overflowed.
// Reset clears the point count, the best pair and the drop flag; the store
// needs no clearing since only entries of the current set are read.
module closest_point_pair #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 10
) (
    input logic      clk,
    input logic      rst_n,
    cpp_chan_if.sink points,
    cpp_chan_if.source result
);

    localparam int OW    = cpp_pkg::COORD_W;
    localparam int DSW   = cpp_pkg::DIST_W;
    localparam int CW    = (COORD_BITS < OW) ? COORD_BITS : OW;
    localparam int PW    = 2 * CW;
    localparam int DW    = 2 * CW + 2;
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_RD_I       = 4'd1;
    localparam logic [3:0] S_LATCH_I    = 4'd2;
    localparam logic [3:0] S_SCAN       = 4'd3;
    localparam logic [3:0] S_DRAIN      = 4'd4;
    localparam logic [3:0] S_FETCH_A    = 4'd5;
    localparam logic [3:0] S_FETCH_B    = 4'd6;
    localparam logic [3:0] S_FETCH_DONE = 4'd7;
    localparam logic [3:0] S_OUT        = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [PW-1:0]    pi_reg;
    logic             rd_vld_reg;
    logic [IW-1:0]    rd_i_reg, rd_j_reg;
    cpp_pkg::pair_result_t res_reg;

    logic             in_fire;
    logic             full;
    logic [CNT_W-1:0] count_after;
    logic             drop_after;
    logic             j_last, i_last;
    logic             issue;
    logic             load_pi, load_few, load_a, load_b, clear_set;
    logic [IW-1:0]    raddr;
    logic [PW-1:0]    rdata;
    logic [PW-1:0]    wdata;
    logic             unit_busy, pipe_busy;
    logic [DW-1:0]    best_dist;
    logic [IW-1:0]    best_i, best_j;

    // Input handshake and store fill
    assign points.ready = (state_reg == S_IDLE);
    assign in_fire      = points.valid && points.ready;
    assign full         = (count_reg == CNT_MAX);
    assign count_after  = full ? count_reg : (count_reg + CNT_W'(1));
    assign drop_after   = drop_reg | full;
    assign wdata        = {points.data.point_row[CW-1:0], points.data.point_col[CW-1:0]};

    // End of inner and outer index ranges
    assign j_last    = (CNT_W'(j_reg) == (count_reg - CNT_W'(1)));
    assign i_last    = (CNT_W'(i_reg) == (count_reg - CNT_W'(2)));
    assign pipe_busy = rd_vld_reg | unit_busy;

    cpp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && !full),
        .waddr (count_reg[IW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    cpp_dist_unit #(
        .CW (CW),
        .IW (IW),
        .DW (DW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear_set),
        .in_vld    (rd_vld_reg),
        .p         (pi_reg),
        .q         (rdata),
        .in_i      (rd_i_reg),
        .in_j      (rd_j_reg),
        .busy      (unit_busy),
        .best_dist (best_dist),
        .best_i    (best_i),
        .best_j    (best_j)
    );

    // Sequencer: load, scan pairs, drain, fetch the best pair, hold result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        raddr      = '0;
        issue      = 1'b0;
        load_pi    = 1'b0;
        load_few   = 1'b0;
        load_a     = 1'b0;
        load_b     = 1'b0;
        clear_set  = 1'b0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = count_after;
                    drop_next  = drop_after;
                    if (points.data.last_point)
                    begin
                        if (count_after < CNT_W'(2))
                        begin
                            load_few   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = S_RD_I;
                        end
                    end
                end
            end
            S_RD_I:
            begin
                raddr      = i_reg;
                j_next     = i_reg + IW'(1);
                state_next = S_LATCH_I;
            end
            S_LATCH_I, S_SCAN:
            begin
                load_pi = (state_reg == S_LATCH_I);
                raddr   = j_reg;
                issue   = 1'b1;
                if (j_last)
                begin
                    if (i_last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_SCAN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = S_FETCH_A;
                end
            end
            S_FETCH_A:
            begin
                raddr      = best_i;
                state_next = S_FETCH_B;
            end
            S_FETCH_B:
            begin
                raddr      = best_j;
                load_a     = 1'b1;
                state_next = S_FETCH_DONE;
            end
            S_FETCH_DONE:
            begin
                load_b     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    clear_set  = 1'b1;
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            rd_vld_reg <= issue;
        end
    end

    // Outer point, read tags and result payload
    always_ff @(posedge clk)
    begin
        rd_i_reg <= i_reg;
        rd_j_reg <= j_reg;
        if (load_pi)
        begin
            pi_reg <= rdata;
        end
        if (load_few)
        begin
            res_reg <= cpp_pkg::pair_result_t'({(4 * OW + DSW)'(0), 1'b1, drop_after});
        end
        if (load_a)
        begin
            res_reg.first_row <= OW'(rdata[PW-1:CW]);
            res_reg.first_col <= OW'(rdata[CW-1:0]);
        end
        if (load_b)
        begin
            res_reg.second_row  <= OW'(rdata[PW-1:CW]);
            res_reg.second_col  <= OW'(rdata[CW-1:0]);
            res_reg.min_dist_sq <= DSW'(best_dist);
            res_reg.too_few     <= 1'b0;
            res_reg.overflowed  <= drop_reg;
        end
    end

    assign result.valid = (state_reg == S_OUT);
    assign result.data  = res_reg;

endmodule

>>> src/cpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/cpp_dist_unit.sv
// Pipelined squared-distance unit with running minimum of the pair scan.
module cpp_dist_unit #(
    parameter int CW = 10,
    parameter int IW = 8,
    parameter int DW = 22
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            in_vld,
    input  logic [2*CW-1:0] p,
    input  logic [2*CW-1:0] q,
    input  logic [IW-1:0]   in_i,
    input  logic [IW-1:0]   in_j,
    output logic            busy,
    output logic [DW-1:0]   best_dist,
    output logic [IW-1:0]   best_i,
    output logic [IW-1:0]   best_j
);

    localparam int SW = 2 * CW;

    logic [CW-1:0] p_row, p_col, q_row, q_col;
    logic [CW-1:0] dr_next, dc_next;

    logic          a_vld_reg;
    logic [CW-1:0] a_dr_reg, a_dc_reg;
    logic [IW-1:0] a_i_reg, a_j_reg;

    logic          b_vld_reg;
    logic [SW-1:0] b_sq_r_reg, b_sq_c_reg;
    logic [IW-1:0] b_i_reg, b_j_reg;
    logic [SW-1:0] sq_r_next, sq_c_next;

    logic [DW-1:0] sum;
    logic          better;
    logic [DW-1:0] best_dist_reg;
    logic [IW-1:0] best_i_reg, best_j_reg;

    // Split the stored entries into row and column
    assign p_row = p[SW-1:CW];
    assign p_col = p[CW-1:0];
    assign q_row = q[SW-1:CW];
    assign q_col = q[CW-1:0];

    // Absolute coordinate differences
    assign dr_next = (p_row > q_row) ? (p_row - q_row) : (q_row - p_row);
    assign dc_next = (p_col > q_col) ? (p_col - q_col) : (q_col - p_col);

    // Squares of the differences
    assign sq_r_next = SW'(a_dr_reg) * SW'(a_dr_reg);
    assign sq_c_next = SW'(a_dc_reg) * SW'(a_dc_reg);

    // Sum and strict compare keeps the first pair on ties
    assign sum    = DW'(b_sq_r_reg) + DW'(b_sq_c_reg);
    assign better = b_vld_reg && (sum < best_dist_reg);

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        a_dr_reg   <= dr_next;
        a_dc_reg   <= dc_next;
        a_i_reg    <= in_i;
        a_j_reg    <= in_j;
        b_sq_r_reg <= sq_r_next;
        b_sq_c_reg <= sq_c_next;
        b_i_reg    <= a_i_reg;
        b_j_reg    <= a_j_reg;
    end

    // Running best pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '1;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
        end
        else if (clear)
        begin
            best_dist_reg <= '1;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
        end
        else if (better)
        begin
            best_dist_reg <= sum;
            best_i_reg    <= b_i_reg;
            best_j_reg    <= b_j_reg;
        end
    end

    assign busy      = a_vld_reg | b_vld_reg;
    assign best_dist = best_dist_reg;
    assign best_i    = best_i_reg;
    assign best_j    = best_j_reg;

endmodule

>>> src/cpp_checker.sv
// Port-level checker of the closest point pair block, bound to the top level.
module cpp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input cpp_pkg::point_item_t  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input cpp_pkg::pair_result_t out_data
);

    logic [cpp_pkg::COORD_W-1:0] dr, dc;
    logic [cpp_pkg::DIST_W-1:0]  pair_dist;

    // Recompute the squared distance of the reported pair
    assign dr = (out_data.first_row > out_data.second_row) ?
                (out_data.first_row - out_data.second_row) :
                (out_data.second_row - out_data.first_row);
    assign dc = (out_data.first_col > out_data.second_col) ?
                (out_data.first_col - out_data.second_col) :
                (out_data.second_col - out_data.first_col);
    assign pair_dist = cpp_pkg::DIST_W'(dr) * cpp_pkg::DIST_W'(dr)
                     + cpp_pkg::DIST_W'(dc) * cpp_pkg::DIST_W'(dc);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Take no point while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("point accepted while result pending");

    // Give no result after a point that does not close the set
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.last_point |=> !out_valid)
        else $error("result after a non-final point");

    // Zero the pair fields of a too-few result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_few |->
            out_data.first_row == '0 && out_data.first_col == '0 &&
            out_data.second_row == '0 && out_data.second_col == '0 &&
            out_data.min_dist_sq == '0)
        else $error("too-few result with nonzero pair fields");

    // Match the reported distance to the reported pair
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.too_few |-> out_data.min_dist_sq == pair_dist)
        else $error("reported distance does not fit the pair");

endmodule

bind closest_point_pair cpp_checker u_cpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .in_data   (points.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

>>> sim/tb_closest_point_pair.sv
// Testbench for closest_point_pair: directed and random point sets checked against a pair-scan predictor.
`timescale 1ns / 1ps

module tb_closest_point_pair;

    localparam int CAP            = 256;
    localparam int CRD            = 10;
    localparam int COORD_MAX      = (1 << CRD) - 1;
    localparam int BEST_INIT      = 22'h3FFFFF;
    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_AT        = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    cpp_chan_if #(.data_t(cpp_pkg::point_item_t))  pts_if ();
    cpp_chan_if #(.data_t(cpp_pkg::pair_result_t)) res_if ();

    closest_point_pair #(
        .MAX_POINTS(CAP),
        .COORD_BITS(CRD)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .points(pts_if),
        .result(res_if)
    );

    // Points waiting to be offered, and closest pairs waiting to come out
    cpp_pkg::point_item_t  point_q[$];
    cpp_pkg::pair_result_t closest_q[$];

    // Predictor copy of the point store
    logic [CRD-1:0] held_row [CAP];
    logic [CRD-1:0] held_col [CAP];
    int             held_count = 0;
    logic           held_dropped = 1'b0;

    int           points_taken = 0;
    int           total_points = 0;
    int           pairs_seen = 0;
    int           mismatches = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;
    logic         send_offer;
    logic         take_pair;
    cpp_pkg::pair_result_t want;

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Store one accepted point; on the last one scan every pair and queue the closest
    task automatic predict_closest(input cpp_pkg::point_item_t it);
        int unsigned dr;
        int unsigned dc;
        int unsigned d;
        int unsigned best;
        int          bi;
        int          bj;
        cpp_pkg::pair_result_t r;
        if (held_count < CAP)
        begin
            held_row[held_count] = it.point_row[CRD-1:0];
            held_col[held_count] = it.point_col[CRD-1:0];
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (it.last_point)
        begin
            r = '0;
            r.overflowed = held_dropped;
            if (held_count < 2)
            begin
                r.too_few = 1'b1;
            end
            else
            begin
                best = BEST_INIT;
                bi = 0;
                bj = 0;
                for (int i = 0; i + 1 < held_count; i++)
                begin
                    for (int j = i + 1; j < held_count; j++)
                    begin
                        dr = (held_row[i] > held_row[j]) ? held_row[i] - held_row[j]
                                                         : held_row[j] - held_row[i];
                        dc = (held_col[i] > held_col[j]) ? held_col[i] - held_col[j]
                                                         : held_col[j] - held_col[i];
                        d = dr * dr + dc * dc;
                        // strictly smaller only: the first pair in load order keeps a tie
                        if (d < best)
                        begin
                            best = d;
                            bi = i;
                            bj = j;
                        end
                    end
                end
                r.first_row   = held_row[bi];
                r.first_col   = held_col[bi];
                r.second_row  = held_row[bj];
                r.second_col  = held_col[bj];
                r.min_dist_sq = best[cpp_pkg::DIST_W-1:0];
            end
            closest_q = {closest_q, r};
            held_count = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
            mismatches++;
        end
    endtask

    task automatic add_point(input int r, input int c, input bit last);
        cpp_pkg::point_item_t it;
        it.point_row  = r[cpp_pkg::COORD_W-1:0];
        it.point_col  = c[cpp_pkg::COORD_W-1:0];
        it.last_point = last;
        point_q = {point_q, it};
    endtask

    // Queue a set of n points of a random flavor: spread, clustered, extreme or lattice
    task automatic add_random_set(input int n, input int kind);
        int br;
        int bc;
        int step;
        int r;
        int c;
        br = $urandom_range(0, COORD_MAX);
        bc = $urandom_range(0, COORD_MAX);
        step = $urandom_range(1, 40);
        for (int k = 0; k < n; k++)
        begin
            case (kind)
                1:
                begin
                    r = (br + $urandom_range(0, 3)) & COORD_MAX;
                    c = (bc + $urandom_range(0, 3)) & COORD_MAX;
                end
                2:
                begin
                    r = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1)
                                             : $urandom_range(0, 1);
                    c = $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 1)
                                             : $urandom_range(0, 1);
                end
                3:
                begin
                    r = (br + step * $urandom_range(0, 3)) & COORD_MAX;
                    c = (bc + step * $urandom_range(0, 3)) & COORD_MAX;
                end
                default:
                begin
                    r = $urandom_range(0, COORD_MAX);
                    c = $urandom_range(0, COORD_MAX);
                end
            endcase
            add_point(r, c, k == n - 1);
        end
    endtask

    task automatic add_small_sets(input int upto);
        int sel;
        int n;
        while (point_q.size() < upto)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                n = 1;
            else if (sel <= 7)
                n = $urandom_range(2, 6);
            else if (sel == 8)
                n = $urandom_range(7, 16);
            else
                n = $urandom_range(17, 32);
            add_random_set(n, $urandom_range(0, 3));
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int base;
        // lone point
        add_point(COORD_MAX, COORD_MAX, 1'b1);
        // farthest corners, both diagonals
        add_point(0, 0, 1'b0);
        add_point(COORD_MAX, COORD_MAX, 1'b1);
        add_point(COORD_MAX, 0, 1'b0);
        add_point(0, COORD_MAX, 1'b1);
        // duplicate points
        add_point(5, 5, 1'b0);
        add_point(100, 100, 1'b0);
        add_point(5, 5, 1'b1);
        // ties along a line and at a corner
        add_point(0, 0, 1'b0);
        add_point(0, 2, 1'b0);
        add_point(0, 4, 1'b1);
        add_point(10, 10, 1'b0);
        add_point(10, 12, 1'b0);
        add_point(12, 10, 1'b1);
        // later strictly closer pair
        add_point(0, 0, 1'b0);
        add_point(3, 0, 1'b0);
        add_point(3, 1, 1'b1);
        // alternating bit patterns
        add_point(10'h2AA, 10'h155, 1'b0);
        add_point(10'h155, 10'h2AA, 1'b1);

        // random sets with one exactly full set and one that overflows on its last two items
        base = point_q.size();
        add_small_sets(base + 40);
        add_random_set(CAP, 0);
        add_small_sets(point_q.size() + 50);
        add_random_set(CAP + 2, 0);
        add_small_sets(point_q.size() + 50);
        total_points = point_q.size();

        #0 rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (points_taken < total_points || closest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Point driver: hold an item until taken, then advance or idle for a burst
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_if.valid <= 1'b0;
            pts_if.data  <= '0;
        end
        else
        begin
            send_offer = pts_if.valid;
            if (pts_if.valid && pts_if.ready)
            begin
                predict_closest(pts_if.data);
                points_taken++;
                send_offer = 1'b0;
                if (point_q.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            if (!send_offer)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (point_q.size() > 0)
                begin
                    pts_if.data <= point_q.pop_front();
                    send_offer = 1'b1;
                end
            end
            pts_if.valid <= send_offer;
        end
    end

    // Result monitor: compare each taken item, stall ready in bursts and once for long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                pairs_seen++;
                if (closest_q.size() == 0)
                begin
                    $display("%0t ns: result item with none expected, expected none, actual %p",
                             $time, res_if.data);
                    mismatches++;
                end
                else
                begin
                    want = closest_q.pop_front();
                    check_field("first_row", 32'(want.first_row), 32'(res_if.data.first_row));
                    check_field("first_col", 32'(want.first_col), 32'(res_if.data.first_col));
                    check_field("second_row", 32'(want.second_row),
                                32'(res_if.data.second_row));
                    check_field("second_col", 32'(want.second_col),
                                32'(res_if.data.second_col));
                    check_field("min_dist_sq", 32'(want.min_dist_sq),
                                32'(res_if.data.min_dist_sq));
                    check_field("too_few", 32'(want.too_few), 32'(res_if.data.too_few));
                    check_field("overflowed", 32'(want.overflowed),
                                32'(res_if.data.overflowed));
                end
                // long hold-off so the block backs up onto its input
                if (pairs_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take_pair = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                take_pair = 1'b0;
            end
            else if (point_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                take_pair = 1'b0;
            end
            else
            begin
                take_pair = 1'b1;
            end
            res_if.ready <= take_pair;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n && !(pts_if.valid && pts_if.ready) && !(res_if.valid && res_if.ready))
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule
